>>> hw/rtl/mtmp_pkg.sv
//------------------------------------------------------------------------------
// mtmp_pkg: shared types and constants
// Widths, register indexes and the queue entry type of the matrix product core.
//------------------------------------------------------------------------------
package mtmp_pkg;

    localparam int MAX_ROWS        = 64;
    localparam int MAX_FACTOR_COLS = 16;
    localparam int MAX_DATA_COLS   = 64;
    localparam int VALUE_BITS      = 32;

    localparam int ROW_W  = 6;
    localparam int FCOL_W = 4;
    localparam int DCOL_W = 6;

    localparam logic [1:0] KIND_LOAD_W = 2'd0;
    localparam logic [1:0] KIND_LOAD_V = 2'd1;
    localparam logic [1:0] KIND_COMP   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] REG_ROWS  = 3'd0;
    localparam logic [2:0] REG_FCOLS = 3'd1;
    localparam logic [2:0] REG_DCOLS = 3'd2;
    localparam logic [2:0] REG_MODE  = 3'd3;
    localparam logic [2:0] REG_MASK  = 3'd4;
    localparam logic [2:0] REG_THR   = 3'd5;
    localparam logic [2:0] REG_EPS   = 3'd6;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    // One classified word waiting for the back end.
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
        logic [31:0] ref_value;
    } t_cmd;

endpackage

>>> hw/rtl/mtmp_front.sv
//------------------------------------------------------------------------------
// mtmp_front: input queue
// Accepts words, drops unknown kinds and holds the rest in a four-entry queue.
//------------------------------------------------------------------------------
module mtmp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mtmp_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output mtmp_pkg::t_cmd  o_cmd
);
    import mtmp_pkg::*;

    t_cmd       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 3'd4);
    assign push    = i_valid && o_ready && (i_cmd.kind != KIND_NONE);
    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end

endmodule

>>> hw/rtl/mtmp_divider.sv
//------------------------------------------------------------------------------
// mtmp_divider: sequential signed divider
// Computes (w * 65536) / v truncated toward zero, one quotient bit a cycle.
//------------------------------------------------------------------------------
module mtmp_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_w,
    input  logic signed [31:0] i_v,
    output logic               o_done,
    output logic signed [63:0] o_quot
);
    logic        r_busy, r_neg, n_done;
    logic [5:0]  r_cnt;
    logic [47:0] r_num;
    logic [47:0] r_quo;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic [32:0] trial;
    logic [47:0] absw;

    assign absw  = i_w[31] ? 48'(-{{16{i_w[31]}}, i_w}) << 16 : {i_w, 16'b0};
    assign trial = {r_rem[31:0], r_num[47]} - {1'b0, r_den};
    assign n_done = r_busy && (r_cnt == 6'd47);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= n_done;
            if (i_start)     r_busy <= 1'b1;
            else if (n_done) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= absw;
            r_den <= i_v[31] ? 32'(-i_v) : i_v;
            r_neg <= i_w[31] ^ i_v[31];
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[46:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
            if (!trial[32]) begin
                r_rem <= trial;
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_num[47]};
                r_quo <= {r_quo[46:0], 1'b0};
            end
        end
    end

    assign o_quot = r_neg ? -$signed({16'b0, r_quo}) : $signed({16'b0, r_quo});

endmodule

>>> hw/rtl/mtmp_back.sv
//------------------------------------------------------------------------------
// mtmp_back: storage and sum engine
// Writes loads into the stores and walks rows and columns for compute words.
//------------------------------------------------------------------------------
module mtmp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mtmp_pkg::t_cmd  i_cmd,
    input  logic [6:0]      i_rows,
    input  logic [4:0]      i_fcols,
    input  logic [6:0]      i_dcols,
    input  logic            i_mode,
    input  logic            i_mask,
    input  logic [30:0]     i_thr,
    input  logic [30:0]     i_eps,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [3:0]      o_row,
    output logic [5:0]      o_col,
    output logic [31:0]     o_value,
    output logic            o_last,
    output logic            o_dz
);
    import mtmp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_WAIT = 7'b0000100,
        S_TERM = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_ADD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    logic [31:0] r_wmem [MAX_ROWS*MAX_FACTOR_COLS];
    logic [31:0] r_vmem [MAX_ROWS*MAX_DATA_COLS];
    logic [31:0] r_rmem [MAX_ROWS*MAX_DATA_COLS];

    t_state             r_st;
    logic [3:0]         r_i;
    logic [5:0]         r_j, r_k;
    logic [6:0]         r_nr, r_ndc;
    logic signed [31:0] r_w, r_v, r_r;
    logic signed [63:0] r_acc, r_term, r_res;
    logic               r_dz, r_last, r_ovalid;
    logic               dv_start, dv_done;
    logic signed [63:0] dv_q;
    logic [31:0]        absr;
    logic               incl;
    logic signed [63:0] prod;
    logic [4:0]         nfc;

    assign nfc   = (i_fcols > 5'd16) ? 5'd16 : i_fcols;
    assign absr  = r_r[31] ? 32'(-r_r) : r_r;
    assign incl  = !i_mask || ({1'b0, absr} < {2'b0, i_thr});
    assign prod  = r_w * r_v;
    assign o_ready = (r_st == S_IDLE);
    assign dv_start = (r_st == S_TERM) && incl && i_mode && (r_v != 0);

    mtmp_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(dv_start),
        .i_w    (r_w),
        .i_v    (r_v),
        .o_done (dv_done),
        .o_quot (dv_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            if (i_cmd.kind == KIND_LOAD_W && i_cmd.col < 6'd16)
                r_wmem[{i_cmd.row, i_cmd.col[3:0]}] <= i_cmd.value;
            if (i_cmd.kind == KIND_LOAD_V) begin
                r_vmem[{i_cmd.row, i_cmd.col}] <= i_cmd.value;
                r_rmem[{i_cmd.row, i_cmd.col}] <= i_cmd.ref_value;
            end
        end
        if (r_st == S_RD) begin
            r_w <= r_wmem[{r_k, r_i}];
            r_v <= r_vmem[{r_k, r_j}];
            r_r <= r_rmem[{r_k, r_j}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_st != S_OUT) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && i_cmd.kind == KIND_COMP
                        && {1'b0, i_cmd.row} < {2'b0, nfc}
                        && i_dcols != 7'd0) begin
                        r_i   <= i_cmd.row[3:0];
                        r_j   <= '0;
                        r_k   <= '0;
                        r_nr  <= (i_rows > 7'd64) ? 7'd64 : i_rows;
                        r_ndc <= (i_dcols > 7'd64) ? 7'd64 : i_dcols;
                        r_acc <= '0;
                        r_dz  <= 1'b0;
                        r_st  <= (i_rows == 7'd0) ? S_OUT : S_RD;
                    end
                end
                S_RD:   r_st <= S_WAIT;
                S_WAIT: r_st <= S_TERM;
                S_TERM: begin
                    if (!incl) begin
                        r_term <= '0;
                        r_st   <= S_ADD;
                    end else if (!i_mode) begin
                        r_term <= prod >>> 16;
                        r_st   <= S_ADD;
                    end else if (r_v == 0) begin
                        r_term <= r_w[31] ? SAT_MIN : SAT_MAX;
                        r_dz   <= 1'b1;
                        r_st   <= S_ADD;
                    end else begin
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (dv_done) begin
                        r_term <= dv_q;
                        r_st   <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_acc <= r_acc + r_term;
                    if ({1'b0, r_k} + 7'd1 == r_nr) begin
                        r_st <= S_OUT;
                    end else begin
                        r_k  <= r_k + 6'd1;
                        r_st <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        if (r_acc == 0)
                            r_res <= {33'b0, i_eps};
                        else if (r_acc > SAT_MAX)
                            r_res <= SAT_MAX;
                        else if (r_acc < SAT_MIN)
                            r_res <= SAT_MIN;
                        else
                            r_res <= r_acc;
                        o_row    <= r_i;
                        o_col    <= r_j;
                        o_dz     <= r_dz;
                        r_last   <= ({1'b0, r_j} + 7'd1 == r_ndc);
                        r_ovalid <= 1'b1;
                        r_acc    <= '0;
                        r_dz     <= 1'b0;
                        r_k      <= '0;
                        if ({1'b0, r_j} + 7'd1 == r_ndc) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_j  <= r_j + 6'd1;
                            r_st <= (r_nr == 7'd0) ? S_OUT : S_RD;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_value = r_res[31:0];
    assign o_last  = r_last;

endmodule

>>> hw/rtl/masked_transposed_matrix_product_core.sv
// Load words pass the queue into the stores; throughput is one word per cycle
// while no compute word is in progress. A compute word gives data_columns results;
// each result steps through read, wait, term, the bit-serial divider (divide mode)
// and add for every row in use, then waits in output while the output stalls.
// Reset is synchronous, active low; it restores register defaults, stores stay.
//------------------------------------------------------------------------------
// masked_transposed_matrix_product_core: top level
// Sums W-transpose times or over V with optional outlier masking.
//------------------------------------------------------------------------------
module masked_transposed_matrix_product_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // row, col, value, ref_value
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_row, out_col, result_value, zero pad
    output logic        m_axis_tlast,  // last
    output logic        m_axis_tuser,  // div_zero
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    import mtmp_pkg::*;

    logic [6:0]  r_rows, r_dcols;
    logic [4:0]  r_fcols;
    logic        r_mode, r_mask;
    logic [30:0] r_thr, r_eps;
    t_cmd        in_cmd, q_cmd;
    logic        q_valid, q_ready;
    logic [3:0]  o_row;
    logic [5:0]  o_col;
    logic [31:0] o_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= 7'd64;
            r_fcols <= 5'd16;
            r_dcols <= 7'd64;
            r_mode  <= 1'b0;
            r_mask  <= 1'b0;
            r_thr   <= 31'h7FFF_FFFF;
            r_eps   <= 31'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS:  r_rows  <= i_cfg_data[6:0];
                REG_FCOLS: r_fcols <= i_cfg_data[4:0];
                REG_DCOLS: r_dcols <= i_cfg_data[6:0];
                REG_MODE:  r_mode  <= i_cfg_data[0];
                REG_MASK:  r_mask  <= i_cfg_data[0];
                REG_THR:   r_thr   <= i_cfg_data;
                REG_EPS:   r_eps   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_cmd.kind      = s_axis_tuser;
    assign in_cmd.row       = s_axis_tdata[5:0];
    assign in_cmd.col       = s_axis_tdata[11:6];
    assign in_cmd.value     = s_axis_tdata[43:12];
    assign in_cmd.ref_value = s_axis_tdata[75:44];

    mtmp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_cmd  (in_cmd),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_cmd  (q_cmd)
    );

    mtmp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_cmd  (q_cmd),
        .i_rows (r_rows),
        .i_fcols(r_fcols),
        .i_dcols(r_dcols),
        .i_mode (r_mode),
        .i_mask (r_mask),
        .i_thr  (r_thr),
        .i_eps  (r_eps),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_row  (o_row),
        .o_col  (o_col),
        .o_value(o_val),
        .o_last (m_axis_tlast),
        .o_dz   (m_axis_tuser)
    );

    assign m_axis_tdata = {6'b0, o_val, o_col, o_row};

endmodule
